// ===== hw/rtl/bfc_pkg.sv =====
// ----------------------------------------------------------------------------
// bfc_pkg
// shared types and codes of the buddy free-block tracker
// ----------------------------------------------------------------------------
package bfc_pkg;

    localparam int CMD_W    = 2;
    localparam int LEVEL_W  = 5;
    localparam int START_W  = 16;
    localparam int STATUS_W = 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_SEED    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY   = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_MERGE,
        ST_QREAD,
        ST_QSCAN,
        ST_RESP
    } state_t;

endpackage

// ===== hw/rtl/buddy_free_coalesce.sv =====
// ----------------------------------------------------------------------------
// buddy_free_coalesce
// buddy-system free-block tracker with seed, coalescing release and
// next-free query over a bitmap held in one synchronous memory
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------------
//  in      | in        | in_valid / in_stall  | command, level, start_address
//  out     | out       | out_valid/out_stall | status, result_level, result_start
//
//  seed passes the read, merge and response states; release repeats read and merge
//  for each level visited, up to TOP_LEVEL; query reads, then scans one 32-bit bitmap
//  word per scan step, as the memory read port is registered.
//  after reset a clearing pass writes every bitmap word once,
//  2^(ADDR_BITS-WORD_LOG) words (2048 at the defaults), in_stall high meanwhile.
//  one transaction is in work at a time; a finished result waits in the output
//  register while the next transaction is taken.
//
module buddy_free_coalesce #(
    parameter int MAX_LEVEL = 16,
    parameter int ADDR_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [bfc_pkg::CMD_W-1:0]      command,
    input  logic [bfc_pkg::LEVEL_W-1:0]    level,
    input  logic [bfc_pkg::START_W-1:0]    start_address,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [bfc_pkg::STATUS_W-1:0]   status,
    output logic [bfc_pkg::LEVEL_W-1:0]    result_level,
    output logic [bfc_pkg::START_W-1:0]    result_start
);
    import bfc_pkg::*;

    // top level where merging stops
    localparam int TOP_LEVEL = (MAX_LEVEL < ADDR_BITS) ? MAX_LEVEL : ADDR_BITS;
    // bitmap word geometry: 32-bit words, narrower for tiny address spaces
    localparam int WORD_LOG  = (ADDR_BITS - 1 < 5) ? ADDR_BITS - 1 : 5;
    localparam int WORD_BITS = 1 << WORD_LOG;
    localparam int WA_BITS   = ADDR_BITS - WORD_LOG;
    localparam int WORDS     = 1 << WA_BITS;
    // working widths
    localparam int EXT_W     = ((ADDR_BITS > START_W) ? ADDR_BITS : START_W) + 1;
    localparam int RES_W     = (ADDR_BITS > START_W) ? ADDR_BITS : START_W;
    localparam logic [LEVEL_W-1:0] TOP_LV = LEVEL_W'(TOP_LEVEL);

    // first bit index of a level: 2^A - 2^(A-k+1), taken modulo 2^A
    function automatic logic [ADDR_BITS-1:0] base_of(input logic [LEVEL_W-1:0] k);
        logic [ADDR_BITS:0] span;
        logic [ADDR_BITS:0] neg;
        span = (ADDR_BITS + 1)'(1) << (ADDR_BITS + 1 - int'(k));
        neg  = ~span + (ADDR_BITS + 1)'(1);
        return neg[ADDR_BITS-1:0];
    endfunction

    // bitmap memory
    logic [WORD_BITS-1:0] mem [WORDS];
    logic [WORD_BITS-1:0] rd_data_reg;
    logic [WA_BITS-1:0]   rd_addr;
    logic                 wr_en;
    logic [WA_BITS-1:0]   wr_addr;
    logic [WORD_BITS-1:0] wr_data;

    // control
    state_t               state_reg, state_next;
    logic [WA_BITS-1:0]   clr_cnt_reg, clr_cnt_next;
    logic                 out_valid_reg, out_valid_next;

    // work registers
    logic [CMD_W-1:0]     cmd_reg, cmd_next;
    logic [LEVEL_W-1:0]   lvl_reg, lvl_next;
    logic [ADDR_BITS-1:0] n_reg, n_next;
    logic                 first_reg, first_next;
    logic [ADDR_BITS-1:0] cur_reg, cur_next;
    logic [ADDR_BITS-1:0] end_reg, end_next;
    logic [STATUS_W-1:0]  pst_reg, pst_next;
    logic [LEVEL_W-1:0]   plv_reg, plv_next;
    logic [START_W-1:0]   pstart_reg, pstart_next;
    logic [STATUS_W-1:0]  ost_reg, ost_next;
    logic [LEVEL_W-1:0]   olv_reg, olv_next;
    logic [START_W-1:0]   ostart_reg, ostart_next;

    // decode of the incoming transaction
    logic                 level_ok;
    logic                 aligned;
    logic [EXT_W-1:0]     start_ext;
    logic [EXT_W-1:0]     low_mask;
    logic [EXT_W-1:0]     n_first;
    logic [EXT_W-1:0]     count_ext;
    logic [ADDR_BITS-1:0] in_base;

    // merge step
    logic [ADDR_BITS-1:0] blk_idx;
    logic [WORD_LOG-1:0]  own_pos;
    logic [WORD_BITS-1:0] own_bit;
    logic [WORD_BITS-1:0] bud_bit;
    logic [WORD_BITS-1:0] w_base;
    logic                 merge;
    logic [RES_W-1:0]     blk_start;

    // scan step
    logic [WA_BITS-1:0]   scan_wa;
    logic [WORD_LOG-1:0]  scan_lo;
    logic [ADDR_BITS-1:0] last_idx;
    logic [WA_BITS-1:0]   last_wa;
    logic [WORD_LOG-1:0]  last_lo;
    logic [WORD_BITS-1:0] hit;
    logic                 found;
    logic [WORD_LOG-1:0]  found_pos;
    logic [ADDR_BITS-1:0] found_n;
    logic [RES_W-1:0]     found_start;

    assign in_stall     = (state_reg != ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign status       = ost_reg;
    assign result_level = olv_reg;
    assign result_start = ostart_reg;

    // incoming checks
    always_comb
    begin
        start_ext = EXT_W'(start_address);
        low_mask  = (EXT_W'(1) << level) - EXT_W'(1);
        level_ok  = (level >= LEVEL_W'(1)) && (level <= TOP_LV);
        aligned   = ((start_ext & low_mask) == '0) && ((start_ext >> ADDR_BITS) == '0);
        n_first   = (start_ext + low_mask) >> level;
        count_ext = EXT_W'(1) << (ADDR_BITS - int'(level));
        in_base   = base_of(level);
    end

    // one merge level: the block and its buddy share a word
    always_comb
    begin
        blk_idx   = base_of(lvl_reg) + n_reg;
        own_pos   = blk_idx[WORD_LOG-1:0];
        own_bit   = WORD_BITS'(1) << own_pos;
        bud_bit   = WORD_BITS'(1) << (own_pos ^ WORD_LOG'(1));
        w_base    = first_reg ? (rd_data_reg & ~own_bit) : rd_data_reg;
        merge     = (cmd_reg == CMD_RELEASE) && ((rd_data_reg & bud_bit) != '0)
                    && (lvl_reg < TOP_LV);
        blk_start = RES_W'(n_reg) << lvl_reg;
    end

    // one scanned word: bits between the current index and the level end
    always_comb
    begin
        scan_wa   = cur_reg[ADDR_BITS-1:WORD_LOG];
        scan_lo   = cur_reg[WORD_LOG-1:0];
        last_idx  = end_reg - ADDR_BITS'(1);
        last_wa   = last_idx[ADDR_BITS-1:WORD_LOG];
        last_lo   = last_idx[WORD_LOG-1:0];
        found     = 1'b0;
        found_pos = '0;
        for (int j = 0; j < WORD_BITS; j++)
        begin
            hit[j] = rd_data_reg[j] && (WORD_LOG'(j) >= scan_lo)
                     && ((scan_wa != last_wa) || (WORD_LOG'(j) <= last_lo));
        end
        for (int j = WORD_BITS - 1; j >= 0; j--)
        begin
            if (hit[j])
            begin
                found     = 1'b1;
                found_pos = WORD_LOG'(j);
            end
        end
        found_n     = {scan_wa, found_pos} - base_of(lvl_reg);
        found_start = RES_W'(found_n) << lvl_reg;
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        out_valid_next = out_valid_reg;
        cmd_next       = cmd_reg;
        lvl_next       = lvl_reg;
        n_next         = n_reg;
        first_next     = first_reg;
        cur_next       = cur_reg;
        end_next       = end_reg;
        pst_next       = pst_reg;
        plv_next       = plv_reg;
        pstart_next    = pstart_reg;
        ost_next       = ost_reg;
        olv_next       = olv_reg;
        ostart_next    = ostart_reg;
        rd_addr        = blk_idx[ADDR_BITS-1:WORD_LOG];
        wr_en          = 1'b0;
        wr_addr        = blk_idx[ADDR_BITS-1:WORD_LOG];
        wr_data        = '0;

        // output register drains independently of the work in progress
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                wr_en        = 1'b1;
                wr_addr      = clr_cnt_reg;
                wr_data      = '0;
                clr_cnt_next = clr_cnt_reg + WA_BITS'(1);
                if (clr_cnt_reg == WA_BITS'(WORDS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next    = command;
                    lvl_next    = level;
                    first_next  = 1'b1;
                    n_next      = ADDR_BITS'(start_ext >> level);
                    pst_next    = STATUS_BAD;
                    plv_next    = level;
                    pstart_next = start_address;
                    state_next  = ST_RESP;
                    if (level_ok && (command == CMD_SEED || command == CMD_RELEASE) && aligned)
                    begin
                        state_next = ST_READ;
                    end
                    else if (level_ok && command == CMD_QUERY)
                    begin
                        cur_next = in_base + ADDR_BITS'(n_first);
                        end_next = in_base + ADDR_BITS'(count_ext);
                        if (n_first >= count_ext)
                        begin
                            pst_next    = STATUS_MISS;
                            pstart_next = '0;
                        end
                        else
                        begin
                            state_next = ST_QREAD;
                        end
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_MERGE;
            end
            ST_MERGE:
            begin
                wr_en      = 1'b1;
                first_next = 1'b0;
                if (merge)
                begin
                    // buddy free: take it out and climb one level
                    wr_data    = w_base & ~bud_bit;
                    n_next     = n_reg >> 1;
                    lvl_next   = lvl_reg + LEVEL_W'(1);
                    state_next = ST_READ;
                end
                else
                begin
                    wr_data     = w_base | own_bit;
                    pst_next    = STATUS_OK;
                    plv_next    = lvl_reg;
                    pstart_next = blk_start[START_W-1:0];
                    state_next  = ST_RESP;
                end
            end
            ST_QREAD:
            begin
                rd_addr    = cur_reg[ADDR_BITS-1:WORD_LOG];
                state_next = ST_QSCAN;
            end
            ST_QSCAN:
            begin
                // fetch the following word while this one is checked
                rd_addr = scan_wa + WA_BITS'(1);
                if (found)
                begin
                    pst_next    = STATUS_OK;
                    plv_next    = lvl_reg;
                    pstart_next = found_start[START_W-1:0];
                    state_next  = ST_RESP;
                end
                else if (scan_wa == last_wa)
                begin
                    pst_next    = STATUS_MISS;
                    plv_next    = lvl_reg;
                    pstart_next = '0;
                    state_next  = ST_RESP;
                end
                else
                begin
                    cur_next = {scan_wa + WA_BITS'(1), WORD_LOG'(0)};
                end
            end
            ST_RESP:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    ost_next       = pst_reg;
                    olv_next       = plv_reg;
                    ostart_next    = pstart_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        lvl_reg    <= lvl_next;
        n_reg      <= n_next;
        first_reg  <= first_next;
        cur_reg    <= cur_next;
        end_reg    <= end_next;
        pst_reg    <= pst_next;
        plv_reg    <= plv_next;
        pstart_reg <= pstart_next;
        ost_reg    <= ost_next;
        olv_reg    <= olv_next;
        ostart_reg <= ostart_next;
    end

    // bitmap memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

endmodule

// ===== hw/rtl/bfc_checker.sv =====
// ----------------------------------------------------------------------------
// bfc_checker
// port-level checks of the buddy free-block tracker
// ----------------------------------------------------------------------------
module bfc_checker #(
    parameter int MAX_LEVEL = 16,
    parameter int ADDR_BITS = 16
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_stall,
    input logic [bfc_pkg::CMD_W-1:0]      command,
    input logic [bfc_pkg::LEVEL_W-1:0]    level,
    input logic [bfc_pkg::START_W-1:0]    start_address,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic [bfc_pkg::STATUS_W-1:0]   status,
    input logic [bfc_pkg::LEVEL_W-1:0]    result_level,
    input logic [bfc_pkg::START_W-1:0]    result_start
);
    import bfc_pkg::*;

    localparam int TOP_LEVEL = (MAX_LEVEL < ADDR_BITS) ? MAX_LEVEL : ADDR_BITS;
    localparam logic [LEVEL_W-1:0] TOP_LV = LEVEL_W'(TOP_LEVEL);

    logic [31:0] lvl_mask;

    assign lvl_mask = (32'd1 << result_level) - 32'd1;

    // a stalled input transaction holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(command)
            && $stable(level) && $stable(start_address))
        else $error("input changed while stalled");

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status)
            && $stable(result_level) && $stable(result_start))
        else $error("result changed while stalled");

    // only defined status codes
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == STATUS_OK || status == STATUS_BAD || status == STATUS_MISS))
        else $error("undefined status code");

    // a miss reports start zero
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STATUS_MISS |-> result_start == '0)
        else $error("miss with nonzero start");

    // a good result is a legal block: level in range and start aligned
    a_ok_block: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STATUS_OK |-> result_level >= LEVEL_W'(1)
            && result_level <= TOP_LV && (32'(result_start) & lvl_mask) == 32'd0)
        else $error("ok result is not an aligned block");

endmodule

bind buddy_free_coalesce bfc_checker #(
    .MAX_LEVEL (MAX_LEVEL),
    .ADDR_BITS (ADDR_BITS)
) u_bfc_checker (.*);

// ===== tb/free_map_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// free_map_check
// watches both channels of the buddy free-block tracker, keeps its own copy
// of the per-level free bits and compares every response with the oldest
// predicted one
// ----------------------------------------------------------------------------
module free_map_check #(
    parameter int MAX_LEVEL = 16,
    parameter int ADDR_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic [bfc_pkg::CMD_W-1:0]    command,
    input  logic [bfc_pkg::LEVEL_W-1:0]  level,
    input  logic [bfc_pkg::START_W-1:0]  start_address,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic [bfc_pkg::STATUS_W-1:0] status,
    input  logic [bfc_pkg::LEVEL_W-1:0]  result_level,
    input  logic [bfc_pkg::START_W-1:0]  result_start,
    output int                           fail_count,
    output int                           outstanding,
    output int                           seen_count,
    output int                           merge_count,
    output int                           miss_count,
    output int                           reject_count
);
    import bfc_pkg::*;

    localparam int TOP_LEVEL = (MAX_LEVEL < ADDR_BITS) ? MAX_LEVEL : ADDR_BITS;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [LEVEL_W-1:0]  level;
        logic [START_W-1:0]  start;
    } response_t;

    // one free bit per block at every level
    bit        free_map [1:TOP_LEVEL][0:(2**(ADDR_BITS-1))-1];
    response_t awaited_responses [$];
    response_t want;
    response_t fresh;
    int        errors;
    int        seen;
    int        merges;
    int        misses;
    int        rejects;

    function automatic response_t predict_response(input logic [CMD_W-1:0] cmd,
                                                   input logic [LEVEL_W-1:0] lvl,
                                                   input logic [START_W-1:0] addr);
        response_t   r;
        int unsigned k;
        int unsigned n;
        int unsigned count;
        bit          aligned;
        bit          found;
        r.status = STATUS_BAD;
        r.level  = lvl;
        r.start  = addr;
        k = lvl;
        if (k >= 1 && k <= TOP_LEVEL)
        begin
            count   = 1 << (ADDR_BITS - k);
            aligned = ((int'(addr) & ((1 << k) - 1)) == 0) && ((int'(addr) >> ADDR_BITS) == 0);
            if (cmd == CMD_SEED && aligned)
            begin
                free_map[k][int'(addr) >> k] = 1'b1;
                r.status = STATUS_OK;
            end
            else if (cmd == CMD_RELEASE && aligned)
            begin
                n = int'(addr) >> k;
                free_map[k][n] = 1'b0;
                // climb while the buddy is free, below the top level
                while (k < TOP_LEVEL && free_map[k][n ^ 1])
                begin
                    free_map[k][n ^ 1] = 1'b0;
                    n = n >> 1;
                    k++;
                end
                free_map[k][n] = 1'b1;
                r.status = STATUS_OK;
                r.level  = LEVEL_W'(k);
                r.start  = START_W'(n << k);
            end
            else if (cmd == CMD_QUERY)
            begin
                // unaligned bound rounds up to the next block start
                n = (int'(addr) + (1 << k) - 1) >> k;
                r.status = STATUS_MISS;
                r.start  = '0;
                found    = 1'b0;
                while (!found && n < count)
                begin
                    if (free_map[k][n])
                    begin
                        found    = 1'b1;
                        r.status = STATUS_OK;
                        r.start  = START_W'(n << k);
                    end
                    else
                        n++;
                end
            end
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // response side first, so a stray response is never matched to a
            // transaction taken at the same edge
            if (out_valid && !out_stall)
            begin
                seen++;
                if (awaited_responses.size() == 0)
                begin
                    $error("response with none awaited: status %0d level %0d start 0x%04h",
                           status, result_level, result_start);
                    errors++;
                end
                else
                begin
                    want = awaited_responses.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        errors++;
                    end
                    if (result_level !== want.level)
                    begin
                        $error("result_level: expected %0d, got %0d", want.level, result_level);
                        errors++;
                    end
                    if (result_start !== want.start)
                    begin
                        $error("result_start: expected 0x%04h, got 0x%04h",
                               want.start, result_start);
                        errors++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                fresh = predict_response(command, level, start_address);
                awaited_responses.push_back(fresh);
                if (fresh.status == STATUS_BAD)
                    rejects++;
                else if (fresh.status == STATUS_MISS)
                    misses++;
                else if (command == CMD_RELEASE && fresh.level != level)
                    merges++;
            end
        end
        fail_count   <= errors;
        outstanding  <= awaited_responses.size();
        seen_count   <= seen;
        merge_count  <= merges;
        miss_count   <= misses;
        reject_count <= rejects;
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the buddy free-block tracker: a directed opener
// over the corner cases, then random traffic focused on small address
// windows so buddies meet and coalesce, under three idle mixes
// ----------------------------------------------------------------------------
module tb;

    import bfc_pkg::*;

    localparam int TOP_LEVEL    = 16;
    localparam int RESET_CYCLES = 9;
    // long output hold-off, enough to back the block up into its input
    localparam int HOLD_CYCLES  = 300;
    // worst release climbs to the top level, leave a margin after draining
    localparam int TAIL_CYCLES  = 40;
    // the one command code the block does not define
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [CMD_W-1:0]    command;
    logic [LEVEL_W-1:0]  level;
    logic [START_W-1:0]  start_address;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [LEVEL_W-1:0]  result_level;
    logic [START_W-1:0]  result_start;

    // idle percentages of sender and receiver
    int in_idle_pct  = 33;
    int out_idle_pct = 65;

    // hold-off request handshake between the stimulus and the stall process
    int hold_req  = 0;
    int hold_ack  = 0;
    int hold_left = 0;

    // address window that the focused random traffic works in
    int unsigned region_lvl;
    int unsigned region_base;

    int fail_count;
    int outstanding;
    int seen_count;
    int merge_count;
    int miss_count;
    int reject_count;

    buddy_free_coalesce dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .level         (level),
        .start_address (start_address),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .result_level  (result_level),
        .result_start  (result_start)
    );

    free_map_check #(
        .MAX_LEVEL (16),
        .ADDR_BITS (16)
    ) u_free_map_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .level         (level),
        .start_address (start_address),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .result_level  (result_level),
        .result_start  (result_start),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .seen_count    (seen_count),
        .merge_count   (merge_count),
        .miss_count    (miss_count),
        .reject_count  (reject_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // receiver: random stalls, or a counted hold-off when one is requested
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (hold_req != hold_ack)
        begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < out_idle_pct);
    end

    // offer one transaction, after a random idle gap, and wait until taken
    task automatic offer(input logic [CMD_W-1:0] cmd, input logic [LEVEL_W-1:0] lvl,
                         input logic [START_W-1:0] addr);
        if ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < in_idle_pct);
        end
        in_valid      <= 1'b1;
        command       <= cmd;
        level         <= lvl;
        start_address <= addr;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // sender pauses until every awaited response has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // new address window; mostly small so releases find their buddies
    task automatic pick_region();
        if ($urandom_range(7) == 0)
            region_lvl = 12;
        else
            region_lvl = $urandom_range(10, 3);
        region_base = $urandom & ~((1 << region_lvl) - 1) & 32'hffff;
    endtask

    task automatic random_item();
        int unsigned        span;
        int unsigned        k;
        int unsigned        roll;
        logic [CMD_W-1:0]   cmd;
        logic [LEVEL_W-1:0] lvl;
        logic [START_W-1:0] addr;
        span = 1 << region_lvl;
        roll = $urandom_range(99);
        if (roll < 70)
        begin
            // well-formed traffic inside the window
            k    = $urandom_range(region_lvl, 1);
            lvl  = LEVEL_W'(k);
            addr = START_W'(region_base + ($urandom & (span - 1) & ~((1 << k) - 1)));
            roll = $urandom_range(99);
            if (roll < 55)
                cmd = CMD_RELEASE;
            else if (roll < 70)
                cmd = CMD_SEED;
            else if (roll < 95)
            begin
                // query bound need not be aligned
                cmd  = CMD_QUERY;
                addr = START_W'(region_base + ($urandom & (span - 1)));
            end
            else
            begin
                // broken release: a low bit set below the block size
                cmd  = CMD_RELEASE;
                addr = addr | START_W'(1 << $urandom_range(k - 1, 0));
            end
        end
        else if (roll < 85)
        begin
            // any legal level, aligned, anywhere in the space
            k    = $urandom_range(TOP_LEVEL, 1);
            lvl  = LEVEL_W'(k);
            addr = START_W'($urandom & ~((1 << k) - 1));
            roll = $urandom_range(99);
            if (roll < 40)
                cmd = CMD_RELEASE;
            else if (roll < 70)
                cmd = CMD_SEED;
            else
                cmd = CMD_QUERY;
        end
        else
        begin
            // noise: every field fully random, bad levels and codes included
            cmd  = CMD_W'($urandom);
            lvl  = LEVEL_W'($urandom);
            addr = START_W'($urandom);
        end
        offer(cmd, lvl, addr);
    endtask

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % 80 == 0)
                pick_region();
            random_item();
        end
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        command       <= CMD_SEED;
        level         <= '0;
        start_address <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // ---- directed opener ----
        // whole space as one block at the top level, no merge possible
        offer(CMD_RELEASE, 5'd16, 16'h0000);
        offer(CMD_QUERY,   5'd16, 16'h0000);
        // unaligned bound rounds past the only top-level block
        offer(CMD_QUERY,   5'd16, 16'h0001);
        // two halves merge up into the top level
        offer(CMD_RELEASE, 5'd15, 16'h0000);
        offer(CMD_RELEASE, 5'd15, 16'h8000);
        // seed does not merge, each release then climbs one level
        offer(CMD_SEED,    5'd1,  16'h0000);
        offer(CMD_RELEASE, 5'd1,  16'h0002);
        offer(CMD_RELEASE, 5'd2,  16'h0004);
        // releasing a block that is already free
        offer(CMD_RELEASE, 5'd3,  16'h0000);
        offer(CMD_RELEASE, 5'd3,  16'h0000);
        // highest smallest block, queries around it
        offer(CMD_SEED,    5'd1,  16'hfffe);
        offer(CMD_QUERY,   5'd1,  16'hffff);
        offer(CMD_QUERY,   5'd1,  16'hfffe);
        offer(CMD_QUERY,   5'd1,  16'h0001);
        // misaligned starts
        offer(CMD_SEED,    5'd3,  16'h0004);
        offer(CMD_RELEASE, 5'd2,  16'h0002);
        // bad levels
        offer(CMD_RELEASE, 5'd0,  16'h0000);
        offer(CMD_QUERY,   5'd17, 16'h0000);
        offer(CMD_SEED,    5'd31, 16'hffff);
        // undefined command
        offer(CMD_UNUSED,  5'd4,  16'h0010);
        // query that finds nothing
        offer(CMD_QUERY,   5'd14, 16'h0000);
        offer(CMD_SEED,    5'd8,  16'hff00);
        offer(CMD_QUERY,   5'd8,  16'h1234);
        offer(CMD_RELEASE, 5'd1,  16'hfffe);
        drain_results();

        // ---- random: sender idles less than receiver ----
        run_random(620);
        drain_results();

        // ---- random: receiver idles less than sender ----
        in_idle_pct  <= 65;
        out_idle_pct <= 33;
        run_random(620);
        drain_results();

        // ---- random: no idling, opened by a long output hold-off ----
        in_idle_pct  <= 0;
        out_idle_pct <= 0;
        hold_req     <= hold_req + 1;
        run_random(640);
        drain_results();

        repeat (TAIL_CYCLES) @(posedge clk);

        $display("run covered %0d transactions: %0d coalescing releases, %0d query misses, %0d rejected",
                 seen_count, merge_count, miss_count, reject_count);
        $display("idle mixes 33/65, 65/33 and none, plus a %0d-cycle output hold-off",
                 HOLD_CYCLES);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // timeout well beyond the slowest legal run
    initial
    begin
        #(60_000_000);
        $display("Some tests failed");
        $finish;
    end

endmodule
